[hw/rtl/bcsf_pkg.sv]
// Shared types and constants of the binary cave smoothing filter.
package bcsf_pkg;

  // APB register map: byte address is four times the register index.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  // Register field widths and reset values.
  localparam int unsigned THR_W = 4;
  localparam int unsigned DIM_W = 9;
  localparam int unsigned ROW_W = 8;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 4'd5;
  localparam logic [DIM_W-1:0] WIDTH_RST     = 9'd80;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 9'd50;

  // Smallest map side and largest map height.
  localparam logic [DIM_W-1:0] MIN_DIM    = 9'd3;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 9'd256;

  // Stream payload widths.
  localparam int unsigned TDATA_W = 8;

  // Datapath settings, plus a one-cycle restart strobe on each register write.
  typedef struct packed {
    logic             restart;
    logic [THR_W-1:0] threshold;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // One result produced by the datapath in the cycle its input beat is taken.
  typedef struct packed {
    logic valid;
    logic wall;
    logic last;
  } res_t;

endpackage

[hw/rtl/bcsf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module bcsf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bcsf_cfg.sv]
// APB register file holding threshold, map width and map height.
module bcsf_cfg import bcsf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [THR_W-1:0] threshold_q, threshold_d;
  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;
  logic [1:0]       index;
  logic             wr_en;
  logic             restart;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // Register write decode; any write to a known register restarts the map.
  always_comb begin
    threshold_d = threshold_q;
    width_d     = width_q;
    height_d    = height_q;
    restart     = 1'b0;
    if (wr_en) begin
      case (index)
        REG_THRESHOLD: begin
          threshold_d = pwdata[THR_W-1:0];
          restart     = 1'b1;
        end
        REG_WIDTH: begin
          width_d = pwdata[DIM_W-1:0];
          restart = 1'b1;
        end
        REG_HEIGHT: begin
          height_d = pwdata[DIM_W-1:0];
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else begin
      threshold_q <= threshold_d;
      width_q     <= width_d;
      height_q    <= height_d;
    end
  end

  // Read mux.
  always_comb begin
    case (index)
      REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, threshold_q};
      REG_WIDTH:     prdata = {{(DATA_W-DIM_W){1'b0}}, width_q};
      REG_HEIGHT:    prdata = {{(DATA_W-DIM_W){1'b0}}, height_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.restart   = restart;
  assign cfg_o.threshold = threshold_q;
  assign cfg_o.width     = width_q;
  assign cfg_o.height    = height_q;

endmodule

[hw/rtl/bcsf_pass.sv]
// Smoothing datapath: raster counters, two row stores, 3x3 window and wall rule.
module bcsf_pass import bcsf_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic acc_i,
  input  logic cell_i,
  input  logic drain_i,
  output res_t res_o
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  logic [CW-1:0]    in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic             tail_q, tail_d;
  logic [CW-1:0]    out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [8:0]       win_q, win_d;
  logic             fwd_q, fwd_d;
  logic             prev_fwd_q, older_fwd_q;

  logic [CW-1:0]    wlast;
  logic [ROW_W-1:0] hlast;
  logic [CW-1:0]    rd_addr;
  logic             we;
  logic             prev_ram, older_ram;
  logic             prev_rd, older_rd;
  logic [8:0]       win_new;
  logic [3:0]       walls;
  logic             started;
  logic             border;
  logic             in_wrap;
  logic             out_wrap;
  logic             out_final;

  // Last column and last row after clamping the map size to its legal range.
  always_comb begin
    if (cfg_i.width < MIN_DIM) begin
      wlast = CW'(2);
    end else if (int'(cfg_i.width) > MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(cfg_i.width - 9'd1);
    end
    if (cfg_i.height < MIN_DIM) begin
      hlast = 8'd2;
    end else if (cfg_i.height > MAX_HEIGHT) begin
      hlast = 8'd255;
    end else begin
      hlast = 8'(cfg_i.height - 9'd1);
    end
  end

  // Row stores: the previous row and the row before it, one cell per column.
  bcsf_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_prev_row (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_col_q),
    .wdata_i (cell_i),
    .raddr_i (rd_addr),
    .rdata_o (prev_ram)
  );

  bcsf_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_older_row (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_col_q),
    .wdata_i (prev_rd),
    .raddr_i (rd_addr),
    .rdata_o (older_ram)
  );

  // A read that hit the column being written takes the freshly written cells.
  assign prev_rd  = fwd_q ? prev_fwd_q : prev_ram;
  assign older_rd = fwd_q ? older_fwd_q : older_ram;

  // Window shift: newest column in the low bits, upper row in the top bit.
  assign win_new = {win_q[5:0], older_rd, prev_rd, cell_i};

  // Neighbor wall count, the center cell excluded.
  always_comb begin
    walls = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != 4) begin
        walls = walls + {3'd0, win_new[b]};
      end
    end
  end

  assign started   = (in_row_q >= 8'd2) || (in_row_q == 8'd1 && in_col_q != '0);
  assign border    = (out_row_q == '0) || (out_row_q >= hlast) ||
                     (out_col_q == '0) || (out_col_q >= wlast);
  assign in_wrap   = (in_col_q >= wlast);
  assign out_wrap  = (out_col_q >= wlast);
  assign out_final = (out_row_q >= hlast) && out_wrap;

  // Next state of counters and window, and the result of the beat taken now.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    tail_d    = tail_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    win_d     = win_q;
    we        = 1'b0;
    res_o     = '0;
    if (cfg_i.restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      tail_d    = 1'b0;
      out_col_d = '0;
      out_row_d = '0;
      win_d     = '0;
    end else if (acc_i) begin
      if (!tail_q) begin
        // Map still arriving: drain beats are dropped.
        if (!drain_i) begin
          we    = 1'b1;
          win_d = win_new;
          if (in_wrap) begin
            in_col_d = '0;
            if (in_row_q >= hlast) begin
              in_row_d = '0;
              tail_d   = 1'b1;
            end else begin
              in_row_d = in_row_q + 8'd1;
            end
          end else begin
            in_col_d = in_col_q + CW'(1);
          end
          if (started) begin
            res_o.valid = 1'b1;
            res_o.wall  = border ? win_new[4] : (walls >= cfg_i.threshold);
            if (out_wrap) begin
              out_col_d = '0;
              out_row_d = out_row_q + 8'd1;
            end else begin
              out_col_d = out_col_q + CW'(1);
            end
          end
        end
      end else begin
        // Tail: remaining cells are border cells read back from the row stores.
        res_o.valid = 1'b1;
        res_o.wall  = (out_row_q >= hlast) ? prev_rd : older_rd;
        res_o.last  = out_final;
        if (out_final) begin
          tail_d    = 1'b0;
          out_col_d = '0;
          out_row_d = '0;
          win_d     = '0;
        end else if (out_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + 8'd1;
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  // Read address runs one beat ahead so the registered read is ready in time.
  assign rd_addr = tail_d ? out_col_d : in_col_d;
  assign fwd_d   = we && (in_col_q == rd_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      tail_q    <= 1'b0;
      out_col_q <= '0;
      out_row_q <= '0;
      win_q     <= '0;
      fwd_q     <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      tail_q    <= tail_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      win_q     <= win_d;
      fwd_q     <= fwd_d;
    end
  end

  // Cells written this beat, kept for a read of the same column.
  always_ff @(posedge clk_i) begin
    prev_fwd_q  <= cell_i;
    older_fwd_q <= prev_rd;
  end

  // Forwarding only happens on the step from the last input cell into the tail.
  a_fwd_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> tail_q)
    else $error("row store forward outside the tail");

  // Input position rests at the origin for the whole tail.
  a_tail_in_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q |-> (in_col_q == '0 && in_row_q == '0))
    else $error("input position moved during the tail");

  // The final cell of a map comes only from the tail.
  a_last_in_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.last) |-> tail_q)
    else $error("frame end flagged while the map is still arriving");

  // After the final cell everything is back at the start of a new map.
  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.last) |=>
      (!tail_q && out_col_q == '0 && out_row_q == '0 && win_q == '0))
    else $error("state not cleared after the final cell");

endmodule

[hw/rtl/binary_cave_smoothing_filter_core.sv]
// Top level of the binary cave smoothing filter: ports, settings and output register.
//
//   channel  direction  handshake               payload
//   s_axis   in         tvalid/tready           tdata[0] cell_is_wall, tuser drain
//   m_axis   out        tvalid/tready           tdata[0] out_is_wall, tlast frame_last
//   apb      in         psel/penable/pready     threshold 0x0, width 0x4, height 0x8
//
// One cell beat is taken per clock while the output is not stalled; the wall count
// and compare sit between the row store read register and the output register.
// Results trail the input by one row plus one cell; map_width + 1 drain beats push
// out the tail. The output register lets a new beat in while a result is taken.
// Reset returns threshold 5, width 80, height 50 and the start of a map; the row
// stores are not cleared. A stalled output holds its beat and stops the input.
module binary_cave_smoothing_filter_core import bcsf_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input cells.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,   // [0] cell_is_wall, [7:1] zero
  input  logic               s_axis_tuser,   // [0] drain
  // Smoothed cells.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // [0] out_is_wall, [7:1] zero
  output logic               m_axis_tlast,
  // Configuration.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res;
  logic acc;
  logic out_valid_q, out_valid_d;
  logic out_wall_q;
  logic out_last_q;

  bcsf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  bcsf_pass #(.MAX_WIDTH(MAX_WIDTH)) u_pass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .acc_i   (acc),
    .cell_i  (s_axis_tdata[0]),
    .drain_i (s_axis_tuser),
    .res_o   (res)
  );

  // Output register: load a new result, otherwise empty once the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_wall_q <= res.wall;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TDATA_W-1){1'b0}}, out_wall_q};
  assign m_axis_tlast  = out_last_q;

endmodule
